[rtl/core/clef_pkg.sv]
package clef_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [6:0] WIDTH_MAX = 7'd127;

    // Request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified request: up to two line octets and the end-of-line mark
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] count;
        logic       eol;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_OCT,
        PH_FLF,
        PH_FSP,
        PH_ECR,
        PH_ELF
    } phase_t;

    // UTF-8 lead octet to character size
    function automatic logic [2:0] lead_size(input logic [7:0] b);
        logic [2:0] s;
        begin
            if (b < 8'hC0)      s = 3'd1;
            else if (b < 8'hE0) s = 3'd2;
            else if (b < 8'hF0) s = 3'd3;
            else if (b < 8'hF8) s = 3'd4;
            else if (b < 8'hFC) s = 3'd5;
            else if (b < 8'hFE) s = 3'd6;
            else                s = 3'd1;
            return s;
        end
    endfunction

endpackage

[rtl/core/clef_front.sv]
module clef_front
    import clef_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       in_value,
    input  logic       escape_on,
    input  logic       end_of_line,
    output cmd_t       cmd
);

    logic special;

    assign special = (data_byte == CH_BSL) || (data_byte == CH_SEMI) ||
                     (data_byte == CH_COMMA);

    always_comb
    begin
        cmd.b0    = data_byte;
        cmd.b1    = data_byte;
        cmd.count = 2'd1;
        cmd.eol   = end_of_line;
        if (in_value)
        begin
            if (data_byte == CH_CR)
            begin
                // drop value CR
                cmd.count = 2'd0;
            end
            else if (data_byte == CH_LF)
            begin
                cmd.b0    = CH_BSL;
                cmd.b1    = CH_N;
                cmd.count = 2'd2;
            end
            else if (escape_on && special)
            begin
                cmd.b0    = CH_BSL;
                cmd.count = 2'd2;
            end
        end
    end

endmodule

[rtl/core/clef_queue.sv]
module clef_queue
    import clef_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign head    = q_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_reg] <= push_cmd;
    end

endmodule

[rtl/core/clef_back.sv]
module clef_back
    import clef_pkg::*;
#(
    parameter int FOLD_LIMIT = 75
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    phase_t     phase_reg, phase_next;
    logic       idx_reg, idx_next;
    logic [6:0] width_reg, width_next;
    logic [2:0] pend_reg, pend_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg;
    logic       ol_reg;

    logic       go;
    logic [7:0] oct;
    logic [2:0] size;
    logic [7:0] sum;
    logic       fold;
    logic       more;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;

    assign go   = !empty && (!ov_reg || !out_stall);
    assign oct  = idx_reg ? head.b1 : head.b0;
    assign size = lead_size(oct);
    assign sum  = {1'b0, width_reg} + {5'd0, size};
    assign fold = (pend_reg == 3'd0) && (sum > 8'(FOLD_LIMIT));
    assign more = !idx_reg && (head.count == 2'd2);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        width_next = width_reg;
        pend_next  = pend_reg;
        pop        = 1'b0;
        if (go)
        begin
            case (phase_reg)
                PH_OCT:
                begin
                    if (head.count == 2'd0)
                    begin
                        if (head.eol)
                            phase_next = PH_ELF;
                        else
                            pop = 1'b1;
                    end
                    else if (fold)
                        phase_next = PH_FLF;
                    else
                    begin
                        if (pend_reg != 3'd0)
                            pend_next = pend_reg - 3'd1;
                        else
                        begin
                            width_next = (sum > {1'b0, WIDTH_MAX}) ? WIDTH_MAX : sum[6:0];
                            pend_next  = size - 3'd1;
                        end
                        if (more)
                            idx_next = 1'b1;
                        else if (head.eol)
                            phase_next = PH_ECR;
                        else
                        begin
                            pop      = 1'b1;
                            idx_next = 1'b0;
                        end
                    end
                end
                PH_FLF:
                    phase_next = PH_FSP;
                PH_FSP:
                begin
                    width_next = 7'd1;
                    phase_next = PH_OCT;
                end
                PH_ECR:
                    phase_next = PH_ELF;
                PH_ELF:
                begin
                    width_next = '0;
                    pend_next  = '0;
                    idx_next   = 1'b0;
                    phase_next = PH_OCT;
                    pop        = 1'b1;
                end
                default:
                    phase_next = PH_OCT;
            endcase
        end
    end

    // emitted octet
    always_comb
    begin
        emit      = 1'b1;
        emit_byte = oct;
        emit_last = 1'b0;
        case (phase_reg)
            PH_OCT:
            begin
                if (head.count == 2'd0)
                begin
                    emit      = head.eol;
                    emit_byte = CH_CR;
                end
                else if (fold)
                    emit_byte = CH_CR;
                else
                    emit_last = !more && !head.eol;
            end
            PH_FLF:
                emit_byte = CH_LF;
            PH_FSP:
                emit_byte = CH_SP;
            PH_ECR:
                emit_byte = CH_CR;
            PH_ELF:
            begin
                emit_byte = CH_LF;
                emit_last = 1'b1;
            end
            default:
                emit = 1'b0;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (!ov_reg || !out_stall)
            ov_next = go && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OCT;
            idx_reg   <= 1'b0;
            width_reg <= '0;
            pend_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            width_reg <= width_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            ob_reg <= emit_byte;
            ol_reg <= emit_last;
        end
    end

    assign out_valid   = ov_reg;
    assign out_byte    = ob_reg;
    assign last_of_run = ol_reg;

endmodule

[rtl/core/calendar_line_escape_fold.sv]
// Content-line escaper and folder.
// Input channel (in_valid / in_stall): one request per line octet, with
// data_byte, in_value (value part), escape_on and end_of_line. A request is
// taken on a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one octet per transfer, out_byte,
// with last_of_run high on the final octet that an input request causes.
// Name octets pass unchanged; value CR is dropped, value LF becomes "\n",
// and with escape_on a backslash goes before backslash, ';' and ','.
// Lines fold with CR LF space before a character that would pass FOLD_LIMIT.
// Throughput: the back end emits one octet per cycle while out_stall lets it.
// The first octet of a request passes the queue write and then the output
// register before it sits on the output.
// A four-entry request queue sits between the classifier and the emitter;
// in_stall rises only when it is full.
// When out_stall is high with an octet in the output register, that octet holds and the
// emitter waits; the queue keeps absorbing input until it fills.
// Reset clears the queue, the line width and the owed continuation count.
module calendar_line_escape_fold
    import clef_pkg::*;
#(
    parameter int FOLD_LIMIT = 75
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       in_value,
    input  logic       escape_on,
    input  logic       end_of_line,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    cmd_t front_cmd;
    cmd_t head;
    logic q_empty;
    logic q_full;
    logic q_pop;

    // classify the raw octet into line octets
    clef_front u_front (
        .data_byte   (data_byte),
        .in_value    (in_value),
        .escape_on   (escape_on),
        .end_of_line (end_of_line),
        .cmd         (front_cmd)
    );

    // hold requests until the emitter is free
    clef_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    assign in_stall = q_full;

    // fold and emit, one octet per cycle unless the output stalls
    clef_back #(
        .FOLD_LIMIT (FOLD_LIMIT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

[tb/tb_calendar_line_escape_fold.sv]
module tb_calendar_line_escape_fold;
    timeunit 1ns;
    timeprecision 1ps;

    import clef_pkg::*;

    localparam int FOLD_LIMIT = 75;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Receiver behavior on out_stall, switched per test or per line
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_LONG
    } stall_mode_t;

    // Sender behavior: back to back, or bursts with random gaps
    typedef enum logic {
        GAP_NONE,
        GAP_BURSTY
    } gap_mode_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } folded_t;

    typedef struct packed {
        logic [7:0] b;
        logic       v;
    } line_octet_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       in_value = 1'b0;
    logic       escape_on = 1'b0;
    logic       end_of_line = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;

    // Octets the folder is predicted to emit, oldest first
    folded_t     folded_q[$];
    // Octets caused by the request being predicted right now
    logic [7:0]  step_q[$];
    // Content line under construction
    line_octet_t line_q[$];

    // Predictor copy of the folder state
    logic [6:0]  width_now = 7'd0;
    logic [2:0]  owed_cont = 3'd0;

    stall_mode_t stall_mode = STALL_NONE;
    gap_mode_t   gap_mode = GAP_NONE;
    int          burst_left = 0;
    int          hold_left = 0;
    logic [2:0]  stall_phase = 3'd0;

    int          error_count = 0;
    int          request_count = 0;
    int          result_count = 0;
    int          fold_count = 0;
    folded_t     want;

    calendar_line_escape_fold #(
        .FOLD_LIMIT(FOLD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .in_value(in_value),
        .escape_on(escape_on),
        .end_of_line(end_of_line),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .last_of_run(last_of_run)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Character size from a UTF-8 lead octet; stray continuations and
    // 0xFE/0xFF count as single octets
    function automatic int char_size(input logic [7:0] b);
        casez (b)
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            8'b111110??: return 5;
            8'b1111110?: return 6;
            default:     return 1;
        endcase
    endfunction

    // Emit one line octet through the folder. An octet owed to the current
    // character bypasses the fold check, whatever its value.
    function automatic void emit_line_octet(input logic [7:0] b);
        int size;
        int w;
        if (owed_cont != 3'd0) begin
            owed_cont = owed_cont - 3'd1;
            step_q.push_back(b);
            return;
        end
        size = char_size(b);
        if (int'(width_now) + size > FOLD_LIMIT) begin
            step_q.push_back(CH_CR);
            step_q.push_back(CH_LF);
            step_q.push_back(CH_SP);
            width_now = 7'd1;
            fold_count++;
        end
        step_q.push_back(b);
        w = int'(width_now) + size;
        width_now = (w > int'(WIDTH_MAX)) ? WIDTH_MAX : 7'(w);
        owed_cont = 3'(size - 1);
    endfunction

    // Work out every octet one accepted request causes and queue them,
    // flagging the final one
    function automatic void predict_request(input logic [7:0] b, input logic v,
                                            input logic e, input logic eol);
        step_q.delete();
        if (!v) begin
            emit_line_octet(b);
        end
        else if (b == CH_LF) begin
            emit_line_octet(CH_BSL);
            emit_line_octet(CH_N);
        end
        else if (b != CH_CR) begin
            // value CR is dropped outright
            if (e && (b == CH_BSL || b == CH_SEMI || b == CH_COMMA))
                emit_line_octet(CH_BSL);
            emit_line_octet(b);
        end
        if (eol) begin
            step_q.push_back(CH_CR);
            step_q.push_back(CH_LF);
            width_now = 7'd0;
            owed_cont = 3'd0;
        end
        foreach (step_q[i])
            folded_q.push_back(folded_t'{octet: step_q[i], last: (i == step_q.size() - 1)});
    endfunction

    // Receiver: check each accepted octet against the oldest prediction,
    // then pick the stall for the next cycle. All values read here are the
    // ones present at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (folded_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected octet: expected none, actual %h last %b",
                         $time, out_byte, last_of_run);
            end
            else begin
                want = folded_q.pop_front();
                result_count++;
                if (out_byte !== want.octet) begin
                    error_count++;
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.octet, out_byte);
                end
                if (last_of_run !== want.last) begin
                    error_count++;
                    $display("%0t: last_of_run mismatch: expected %b, actual %b",
                             $time, want.last, last_of_run);
                end
            end
        end

        case (stall_mode)
            STALL_NONE: out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN:
            begin
                // stall on a fixed beat: when bits 2 and 0 of the phase counter are both set
                stall_phase = stall_phase + 3'd1;
                out_stall <= stall_phase[2] & stall_phase[0];
            end
            default:
            begin
                // mostly open, with occasional long holds
                if (hold_left > 0) begin
                    hold_left--;
                    out_stall <= 1'b1;
                end
                else if ($urandom_range(0, 15) == 0) begin
                    hold_left = $urandom_range(4, 12);
                    out_stall <= 1'b1;
                end
                else begin
                    out_stall <= 1'b0;
                end
            end
        endcase
    end

    // Present one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge of acceptance.
    task automatic send_request(input logic [7:0] b, input logic v,
                                input logic e, input logic eol);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_mode == GAP_BURSTY) begin
                gap = $urandom_range(1, 7);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        data_byte <= b;
        in_value <= v;
        escape_on <= e;
        end_of_line <= eol;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_request(b, v, e, eol);
        request_count++;
    endtask

    // Hold the sender off until every predicted octet has come out, then
    // give a dropped CR time to clear the pipeline
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (folded_q.size() != 0);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    // Send the built line, end_of_line on its last octet; escape_on may
    // flip on single octets
    task automatic send_line(input logic esc, input logic flip_escape);
        logic e;
        foreach (line_q[i]) begin
            e = esc;
            if (flip_escape && $urandom_range(0, 9) == 0)
                e = ~e;
            send_request(line_q[i].b, line_q[i].v, e, i == line_q.size() - 1);
        end
    endtask

    // Name and value extremes, every escape path, and the odd lead octets
    task automatic test_directed_octets();
        stall_mode = STALL_RANDOM;
        gap_mode = GAP_BURSTY;
        // name part: specials pass unchanged even with escaping on
        send_request("X", 1'b0, 1'b1, 1'b0);
        send_request(CH_CR, 1'b0, 1'b1, 1'b0);
        send_request(CH_LF, 1'b0, 1'b1, 1'b0);
        send_request(CH_BSL, 1'b0, 1'b1, 1'b0);
        send_request(CH_COMMA, 1'b0, 1'b1, 1'b0);
        send_request(CH_COLON, 1'b0, 1'b1, 1'b0);
        // value part: drop CR, expand LF, escape on and off
        send_request(CH_CR, 1'b1, 1'b1, 1'b0);
        send_request(CH_LF, 1'b1, 1'b0, 1'b0);
        send_request(CH_BSL, 1'b1, 1'b1, 1'b0);
        send_request(CH_SEMI, 1'b1, 1'b1, 1'b0);
        send_request(CH_COMMA, 1'b1, 1'b0, 1'b0);
        send_request(CH_SEMI, 1'b1, 1'b0, 1'b0);
        // zero, top octets and a stray continuation are single characters
        send_request(8'h00, 1'b1, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b1, 1'b0);
        send_request(8'hFE, 1'b1, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b1, 1'b0);
        // an inserted backslash is swallowed as the owed continuation
        send_request(8'hC3, 1'b1, 1'b1, 1'b0);
        send_request(CH_SEMI, 1'b1, 1'b1, 1'b0);
        // five-octet character cut short by end of line
        send_request(8'hF8, 1'b1, 1'b1, 1'b0);
        send_request(8'h88, 1'b1, 1'b1, 1'b1);
        // six-octet lead, then a dropped CR that closes the line
        send_request(8'hFD, 1'b1, 1'b0, 1'b0);
        send_request(CH_CR, 1'b1, 1'b0, 1'b1);
        // one-octet line in the name part
        send_request(8'hFF, 1'b0, 1'b0, 1'b1);
    endtask

    // Hit the fold limit exactly: a three-octet character that would cross
    // it, a character that lands on it, and an escape that crosses it
    task automatic test_fold_boundary();
        stall_mode = STALL_LONG;
        gap_mode = GAP_NONE;
        line_q.delete();
        line_q.push_back('{b: "N", v: 1'b0});
        line_q.push_back('{b: CH_COLON, v: 1'b0});
        repeat (71) line_q.push_back('{b: "a", v: 1'b1});
        line_q.push_back('{b: 8'hE2, v: 1'b1});
        line_q.push_back('{b: 8'h82, v: 1'b1});
        line_q.push_back('{b: 8'hAC, v: 1'b1});
        repeat (70) line_q.push_back('{b: "a", v: 1'b1});
        line_q.push_back('{b: "b", v: 1'b1});
        line_q.push_back('{b: CH_COMMA, v: 1'b1});
        send_line(1'b1, 1'b0);
    endtask

    // Well-formed content lines with random names and values: mostly short
    // values, some long enough to fold several times
    task automatic test_content_lines(input int budget);
        int stop_at;
        int name_len;
        int target;
        int pick;
        int size;
        logic [7:0] lead;
        stop_at = request_count + budget;
        while (request_count < stop_at) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            gap_mode = gap_mode_t'($urandom_range(0, 1));
            line_q.delete();
            name_len = $urandom_range(1, 8);
            repeat (name_len)
                line_q.push_back('{b: 8'($urandom_range(8'h41, 8'h5A)), v: 1'b0});
            line_q.push_back('{b: CH_COLON, v: 1'b0});
            target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 30)
                                                : $urandom_range(60, 200);
            while (line_q.size() < name_len + 1 + target) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    line_q.push_back('{b: 8'($urandom_range(8'h20, 8'h7E)), v: 1'b1});
                end
                else if (pick < 72) begin
                    case ($urandom_range(0, 4))
                        0: lead = CH_CR;
                        1: lead = CH_LF;
                        2: lead = CH_BSL;
                        3: lead = CH_SEMI;
                        default: lead = CH_COMMA;
                    endcase
                    line_q.push_back('{b: lead, v: 1'b1});
                end
                else if (pick < 95) begin
                    // whole multi-octet character, never split by the generator
                    size = $urandom_range(2, 6);
                    case (size)
                        2: lead = 8'($urandom_range(8'hC0, 8'hDF));
                        3: lead = 8'($urandom_range(8'hE0, 8'hEF));
                        4: lead = 8'($urandom_range(8'hF0, 8'hF7));
                        5: lead = 8'($urandom_range(8'hF8, 8'hFB));
                        default: lead = 8'($urandom_range(8'hFC, 8'hFD));
                    endcase
                    line_q.push_back('{b: lead, v: 1'b1});
                    repeat (size - 1)
                        line_q.push_back('{b: 8'($urandom_range(8'h80, 8'hBF)), v: 1'b1});
                end
                else begin
                    line_q.push_back('{b: 8'($urandom), v: 1'b1});
                end
            end
            send_line($urandom_range(0, 3) != 0, 1'b1);
        end
    endtask

    // Arbitrary requests: broken characters, specials in the name, lines
    // cut at random points
    task automatic test_noise(input int count);
        stall_mode = STALL_RANDOM;
        gap_mode = GAP_BURSTY;
        repeat (count)
            send_request(8'($urandom), 1'($urandom), 1'($urandom),
                         $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_octets();
        // pause the sender until the output side is empty
        wait_drained();
        test_fold_boundary();
        wait_drained();
        test_content_lines(200);
        wait_drained();
        test_noise(50);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run covered %0d requests and %0d output octets, %0d of them folds.",
                 request_count, result_count, fold_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
